// ===== rtl/core/drsd_pkg.sv =====
// Shared types and constants for the dual range stillness detector.
// Holds field widths, arithmetic constants, register codes, FSM states
// and the command/status structs between controller and datapath.
package drsd_pkg;

  // Fixed field widths
  localparam int ADC_IN_W   = 10;
  localparam int DIST_W     = 13;
  localparam int DRIFT_W    = 24;
  localparam int RUN_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int LIMIT_W    = 8;

  // Parameter defaults
  localparam int ADC_BITS_DEF  = 10;
  localparam int FRAC_BITS_DEF = 8;

  // Conversion arithmetic
  localparam int MV_FULL   = 5000;
  localparam int TEN_K     = 10000;
  localparam int OFFSET_E4 = 1696;
  localparam int SCALE_E4  = 246100000;  // 24610 * 10000, before the fraction shift
  localparam int SCALE_W   = 28;
  localparam int MV_W      = 13;
  localparam int DEN_W     = 26;         // 5000 * 10000 fits

  localparam logic [RUN_W-1:0]   RUN_MAX   = '1;
  localparam logic [DRIFT_W-1:0] DRIFT_MAX = '1;

  // Register reset values
  localparam logic [DIST_W-1:0]  NOISE_FLOOR_RST = 13'd128;
  localparam logic [DIST_W-1:0]  MOVE_THR_RST    = 13'd384;
  localparam logic [LIMIT_W-1:0] STABLE_LIM_RST  = 8'd10;
  localparam logic [DRIFT_W-1:0] MAX_DRIFT_RST   = 24'd5120;
  localparam logic [DIST_W-1:0]  VALID_MIN_RST   = 13'd2048;
  localparam logic [DIST_W-1:0]  VALID_MAX_RST   = 13'd7680;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NOISE_FLOOR = 3'd0,
    REG_MOVE_THR    = 3'd1,
    REG_STABLE_LIM  = 3'd2,
    REG_MAX_DRIFT   = 3'd3,
    REG_VALID_MIN   = 3'd4,
    REG_VALID_MAX   = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_MV,
    ST_DEN,
    ST_DIST_START,
    ST_DIST_WAIT,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic load_in;   // capture both readings
    logic mul_mv;    // product = adc * 5000
    logic take_mv;   // latch millivolts: product times the full-scale reciprocal
    logic mul_den;   // den = mv * 10000
    logic div_dist;  // start scale / (den - offset)
    logic pick;      // settle the distance of the current channel
    logic use_quo;   // pick from the quotient if it lies in the valid window, else repeat the last distance
    logic update;    // advance the stillness state and load the result
    logic ch;        // current channel, 0 first, 1 second
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic den_pos;
  } dp_status_t;

endpackage

// ===== rtl/core/drsd_divider.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on nothing; instantiated by the datapath.
module drsd_divider #(
  parameter int NUM_W = 36,
  parameter int DVS_W = 26
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] acc;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   trial;
  logic             ge;

  assign trial    = {rem, acc[NUM_W-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign quotient = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
      acc <= {acc[NUM_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/core/drsd_datapath.sv =====
// Datapath: config registers, conversion multipliers, shared divider,
// stillness state and result registers. Depends on drsd_pkg, drsd_divider.
module drsd_datapath #(
  parameter int ADC_BITS  = drsd_pkg::ADC_BITS_DEF,
  parameter int FRAC_BITS = drsd_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  drsd_pkg::dp_cmd_t                 cmd,
  output drsd_pkg::dp_status_t              status,
  input  logic                              cfg_we,
  input  logic [drsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [drsd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [drsd_pkg::ADC_IN_W-1:0]     adc_first,
  input  logic [drsd_pkg::ADC_IN_W-1:0]     adc_second,
  output logic [drsd_pkg::DIST_W-1:0]       dist_first,
  output logic [drsd_pkg::DIST_W-1:0]       dist_second,
  output logic                              still_now,
  output logic                              alarm
);
  import drsd_pkg::*;

  localparam int NUM_W    = SCALE_W + FRAC_BITS;
  localparam int PROD_W   = ADC_BITS + 13;
  localparam int FULL     = (1 << ADC_BITS) - 1;
  localparam int RECIP_SH = PROD_W + ADC_BITS;
  localparam int RECIP_W  = PROD_W + 1;
  localparam int WIDE_W   = PROD_W + RECIP_W;

  // ceil(2^RECIP_SH / FULL): exact floor division for every product below 2^PROD_W
  localparam longint unsigned RECIP_L =
    ((64'd1 << RECIP_SH) + 64'(FULL) - 64'd1) / 64'(FULL);

  localparam logic [NUM_W-1:0]   NUM_VAL   = NUM_W'(SCALE_E4) << FRAC_BITS;
  localparam logic [PROD_W-1:0]  MV_FULL_W = PROD_W'(MV_FULL);
  localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(RECIP_L);
  localparam logic [DEN_W-1:0]   TEN_K_W   = DEN_W'(TEN_K);
  localparam logic [DEN_W-1:0]   OFFSET_W  = DEN_W'(OFFSET_E4);

  function automatic logic [DIST_W-1:0] absdiff(input logic [DIST_W-1:0] a,
                                                input logic [DIST_W-1:0] b);
    absdiff = (a >= b) ? a - b : b - a;
  endfunction

  // Configuration
  logic [DIST_W-1:0]  noise_floor;
  logic [DIST_W-1:0]  move_thr;
  logic [LIMIT_W-1:0] stable_lim;
  logic [DRIFT_W-1:0] max_drift;
  logic [DIST_W-1:0]  valid_min;
  logic [DIST_W-1:0]  valid_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_floor <= NOISE_FLOOR_RST;
      move_thr    <= MOVE_THR_RST;
      stable_lim  <= STABLE_LIM_RST;
      max_drift   <= MAX_DRIFT_RST;
      valid_min   <= VALID_MIN_RST;
      valid_max   <= VALID_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NOISE_FLOOR: noise_floor <= cfg_data[DIST_W-1:0];
        REG_MOVE_THR:    move_thr    <= cfg_data[DIST_W-1:0];
        REG_STABLE_LIM:  stable_lim  <= cfg_data[LIMIT_W-1:0];
        REG_MAX_DRIFT:   max_drift   <= cfg_data[DRIFT_W-1:0];
        REG_VALID_MIN:   valid_min   <= cfg_data[DIST_W-1:0];
        REG_VALID_MAX:   valid_max   <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Conversion
  logic [ADC_BITS-1:0] adc_a;
  logic [ADC_BITS-1:0] adc_b;
  logic [PROD_W-1:0]   prod;
  logic [WIDE_W-1:0]   mv_wide;
  logic [MV_W-1:0]     mv;
  logic [DEN_W-1:0]    den;
  logic [DIST_W-1:0]   d_first;
  logic [DIST_W-1:0]   d_second;

  logic                div_start;
  logic [NUM_W-1:0]    div_dividend;
  logic [DEN_W-1:0]    div_divisor;
  logic                div_done;
  logic [NUM_W-1:0]    quo;
  logic                in_window;
  logic [DIST_W-1:0]   last_sel;
  logic [DIST_W-1:0]   pick_val;

  assign mv_wide      = WIDE_W'(prod) * WIDE_W'(RECIP);
  assign div_start    = cmd.div_dist;
  assign div_dividend = NUM_VAL;
  assign div_divisor  = den - OFFSET_W;

  drsd_divider #(
    .NUM_W (NUM_W),
    .DVS_W (DEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quo)
  );

  // Stillness state
  logic [DIST_W-1:0]  last_first;
  logic [DIST_W-1:0]  last_second;
  logic [DIST_W-1:0]  ref_first;
  logic [DIST_W-1:0]  ref_second;
  logic [DRIFT_W-1:0] drift_sum;
  logic [RUN_W-1:0]   still_run;

  assign status.div_done = div_done;
  assign status.den_pos  = den > OFFSET_W;

  assign in_window = (quo >= NUM_W'(valid_min)) && (quo <= NUM_W'(valid_max));
  assign last_sel  = cmd.ch ? last_second : last_first;
  assign pick_val  = (cmd.use_quo && in_window) ? quo[DIST_W-1:0] : last_sel;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      adc_a <= ADC_BITS'(adc_first);
      adc_b <= ADC_BITS'(adc_second);
    end
    if (cmd.mul_mv) begin
      prod <= PROD_W'(cmd.ch ? adc_b : adc_a) * MV_FULL_W;
    end
    if (cmd.take_mv) begin
      mv <= MV_W'(mv_wide >> RECIP_SH);
    end
    if (cmd.mul_den) begin
      den <= DEN_W'(mv) * TEN_K_W;
    end
    if (cmd.pick) begin
      if (cmd.ch) begin
        d_second <= pick_val;
      end else begin
        d_first <= pick_val;
      end
    end
  end

  logic [DIST_W-1:0]  delta1;
  logic [DIST_W-1:0]  delta2;
  logic               still;
  logic [RUN_W-1:0]   run_inc;
  logic [DRIFT_W+1:0] sum;
  logic [RUN_W-1:0]   still_run_next;
  logic [DRIFT_W-1:0] drift_sum_next;
  logic               latch_ref;

  always_comb begin
    delta1 = absdiff(d_first, last_first);
    delta2 = absdiff(d_second, last_second);
    if (delta1 < noise_floor) delta1 = '0;
    if (delta2 < noise_floor) delta2 = '0;
    still   = (delta1 < move_thr) && (delta2 < move_thr);
    run_inc = (still_run != RUN_MAX) ? still_run + RUN_W'(1) : still_run;
    sum     = {2'b00, drift_sum}
            + (DRIFT_W+2)'(absdiff(d_first, ref_first))
            + (DRIFT_W+2)'(absdiff(d_second, ref_second));
    latch_ref = still && (run_inc == RUN_W'(1));
    if (!still) begin
      still_run_next = '0;
      drift_sum_next = '0;
    end else if (latch_ref) begin
      still_run_next = run_inc;
      drift_sum_next = '0;
    end else begin
      still_run_next = run_inc;
      drift_sum_next = (sum > (DRIFT_W+2)'(DRIFT_MAX)) ? DRIFT_MAX : sum[DRIFT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_first  <= '0;
      last_second <= '0;
      ref_first   <= '0;
      ref_second  <= '0;
      drift_sum   <= '0;
      still_run   <= '0;
    end else if (cmd.update) begin
      last_first  <= d_first;
      last_second <= d_second;
      drift_sum   <= drift_sum_next;
      still_run   <= still_run_next;
      if (latch_ref) begin
        ref_first  <= d_first;
        ref_second <= d_second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      dist_first  <= d_first;
      dist_second <= d_second;
      still_now   <= still;
      alarm       <= (still_run_next >= stable_lim) && (drift_sum_next < max_drift);
    end
  end

endmodule

// ===== rtl/core/drsd_controller.sv =====
// Controller FSM: sequences both channels through the shared divider
// and owns the input and result handshakes. Depends on drsd_pkg.
module drsd_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  output logic                 result_valid,
  input  logic                 result_stall,
  output drsd_pkg::dp_cmd_t    cmd,
  input  drsd_pkg::dp_status_t status
);
  import drsd_pkg::*;

  state_t state;
  state_t state_next;
  logic   ch;
  logic   out_blocked;

  assign out_blocked  = result_valid && result_stall;
  assign sample_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (sample_valid) state_next = ST_PROD;
      ST_PROD:       state_next = ST_MV;
      ST_MV:         state_next = ST_DEN;
      ST_DEN:        state_next = ST_DIST_START;
      ST_DIST_START: begin
        if (status.den_pos) state_next = ST_DIST_WAIT;
        else state_next = ch ? ST_UPDATE : ST_PROD;
      end
      ST_DIST_WAIT:  if (status.div_done) state_next = ch ? ST_UPDATE : ST_PROD;
      ST_UPDATE:     if (!out_blocked) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd    = '0;
    cmd.ch = ch;
    unique case (state)
      ST_IDLE:       cmd.load_in = sample_valid;
      ST_PROD:       cmd.mul_mv  = 1'b1;
      ST_MV:         cmd.take_mv = 1'b1;
      ST_DEN:        cmd.mul_den = 1'b1;
      ST_DIST_START: begin
        cmd.div_dist = status.den_pos;
        cmd.pick     = !status.den_pos;
      end
      ST_DIST_WAIT:  begin
        cmd.pick    = status.div_done;
        cmd.use_quo = 1'b1;
      end
      ST_UPDATE:     cmd.update = !out_blocked;
      default:       ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      ch           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_in) begin
        ch <= 1'b0;
      end else if (cmd.pick) begin
        ch <= 1'b1;
      end
      if (cmd.update) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_rise_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_UPDATE))
    else $error("result_valid rose outside the update state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> !(result_valid && result_stall))
    else $error("held result overwritten");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (state == ST_DIST_WAIT))
    else $error("divider finished outside the wait state");

  a_both_channels: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) |-> ch)
    else $error("update reached before the second channel");

endmodule

// ===== rtl/core/dual_range_stillness_detector_unit.sv =====
// From sample acceptance to result_valid each channel passes in turn through the
// product, millivolt, den and divide states; a zero millivolt reading skips the
// division, and the update state waits while a pending result is held.
// New samples wait until the last one leaves the update state. The shared radix-2
// divider runs up to two divisions (one per channel), 28+FRAC_BITS bits, in turn.
// Reset (rst, synchronous): registers take their defaults, stillness state clears.
// Top level of the dual range stillness detector; uses drsd_pkg and submodules.
module dual_range_stillness_detector_unit #(
  parameter int ADC_BITS  = drsd_pkg::ADC_BITS_DEF,
  parameter int FRAC_BITS = drsd_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // sample channel: one transaction per sampling tick
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  logic [drsd_pkg::ADC_IN_W-1:0]   adc_first,
  input  logic [drsd_pkg::ADC_IN_W-1:0]   adc_second,
  // result channel: one transaction per sample
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [drsd_pkg::DIST_W-1:0]     dist_first,
  output logic [drsd_pkg::DIST_W-1:0]     dist_second,
  output logic                            still_now,
  output logic                            alarm,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [drsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [drsd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import drsd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Registers are plain flops; take a write every cycle.
  assign cfg_ready = 1'b1;

  // Sequence: capture both readings, then per channel
  //   product = adc*5000, multiply by the full-scale reciprocal for millivolts,
  //   den = mv*10000, divide the fixed scale by den-offset if den > offset,
  //   keep the quotient if it lands in the window, else hold the last distance.
  // After the second channel, advance the still run and drift sum and load
  // the result register. A pending result holds the update state and so the next sample.
  drsd_controller u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .status       (status)
  );

  drsd_datapath #(
    .ADC_BITS  (ADC_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .adc_first   (adc_first),
    .adc_second  (adc_second),
    .dist_first  (dist_first),
    .dist_second (dist_second),
    .still_now   (still_now),
    .alarm       (alarm)
  );

endmodule
